FILE: design/assert_macros.svh
// Assertion helpers for the sphere collision impulse engine.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define SCIE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SCIE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/scie_pkg.sv
// Shared types, constants and helper functions for the sphere collision engine.
// No dependencies.
package scie_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 24;
	localparam int QUOT_W      = WEIGHT_BITS + 1;

	localparam logic [16:0] RESTITUTION_RESET = 17'd58982;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_ACCEL   = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;
	localparam logic [1:0] KIND_COLLIDE = 2'd3;

	localparam logic [4:0] NORM_DIV_STEPS   = 5'(FRAC_BITS + 1);
	localparam logic [4:0] WEIGHT_DIV_STEPS = 5'(WEIGHT_BITS + 1);

	localparam logic signed [71:0] FRAC_RND = (72'sd1 <<< FRAC_BITS) - 72'sd1;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		word_t [2:0] pos;
		word_t [2:0] vel;
		logic [30:0] radius;
		logic [30:0] mass;
	} rec_t;

	typedef struct packed {
		logic        start;
		logic [4:0]  count;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] x;
	} sqrt_req_t;

	function automatic word_t sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [55:0] trunc_frac(input logic signed [71:0] p);
		logic signed [71:0] t;
		t = p + (p[71] ? FRAC_RND : 72'sd0);
		return t[71:FRAC_BITS];
	endfunction

endpackage

FILE: design/scie_div.sv
// Restoring divider, one quotient bit per cycle; quotient is num * 2^(count-1) / den.
// Requires num <= den. Depends on scie_pkg.
module scie_div import scie_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [31:0]       rem_q;
	logic [QUOT_W-1:0] sh_q;
	logic              done_q;
	logic [32:0]       trial;
	logic              ge;

	assign trial = {rem_q, sh_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num[31:1]};
			sh_q  <= {req.num[0], {(QUOT_W-1){1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, req.den}) : trial[31:0];
			sh_q  <= {sh_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

FILE: design/scie_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Depends on scie_pkg.
module scie_sqrt import scie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sqrt_req_t   req,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] xs_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] cur;
	logic [35:0] trial;
	logic        ge;

	assign cur   = {rem_q, xs_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			xs_q   <= req.x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			xs_q   <= {xs_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(cur - trial) : cur[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: design/sphere_collision_impulse_engine_unit.sv
// Sphere collision impulse engine: sphere record memory, sequencer and shared datapath.
// Depends on scie_pkg, scie_div, scie_sqrt and assert_macros.svh.
//
//   port group   flow   handshake                  carries
//   req_*        in     req_valid / req_stall      one command (load, accel, advance, collide)
//   rsp_*        out    rsp_valid / rsp_stall      one updated sphere record
//   p*           in     APB write/read             restitution register at address 0
//
// Load, accelerate and advance read, update and write back one record. A collide with
// contact runs the square root unit and up to five divider passes, the last two only
// when an impulse applies. Output stalls hold the sequencer in its emit states.
// The next command is taken while the last record still waits in the output register.
// Reset clears control only; the sphere memory holds garbage until loaded.
`include "assert_macros.svh"

module sphere_collision_impulse_engine_unit import scie_pkg::*; #(
	parameter int SPHERE_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         kind,
	input  logic [5:0]         index_a,
	input  logic [5:0]         index_b,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [30:0]        radius,
	input  logic [30:0]        mass,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [5:0]         sphere_index,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic               contact,
	output logic               last
);

	localparam int AW = (SPHERE_COUNT > 2) ? $clog2(SPHERE_COUNT) : 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RDA  = 5'd1;
	localparam logic [4:0] S_RDB  = 5'd2;
	localparam logic [4:0] S_DIFF = 5'd3;
	localparam logic [4:0] S_SQ   = 5'd4;
	localparam logic [4:0] S_SQA  = 5'd5;
	localparam logic [4:0] S_CHK  = 5'd6;
	localparam logic [4:0] S_SQRT = 5'd7;
	localparam logic [4:0] S_NDIV = 5'd8;
	localparam logic [4:0] S_NDW  = 5'd9;
	localparam logic [4:0] S_RV   = 5'd10;
	localparam logic [4:0] S_RVA  = 5'd11;
	localparam logic [4:0] S_IMP  = 5'd12;
	localparam logic [4:0] S_K    = 5'd13;
	localparam logic [4:0] S_KA   = 5'd14;
	localparam logic [4:0] S_WDIV = 5'd15;
	localparam logic [4:0] S_WDW  = 5'd16;
	localparam logic [4:0] S_KW   = 5'd17;
	localparam logic [4:0] S_KWA  = 5'd18;
	localparam logic [4:0] S_DV   = 5'd19;
	localparam logic [4:0] S_DVA  = 5'd20;
	localparam logic [4:0] S_HALF = 5'd21;
	localparam logic [4:0] S_PS   = 5'd22;
	localparam logic [4:0] S_PSA  = 5'd23;
	localparam logic [4:0] S_WRA  = 5'd24;
	localparam logic [4:0] S_WRB  = 5'd25;
	localparam logic [4:0] S_EMA  = 5'd26;
	localparam logic [4:0] S_EMB  = 5'd27;

	logic [4:0]  state_q;
	logic [2:0]  cnt_q;
	logic [16:0] restitution_q;
	logic        contact_q;
	logic        rsp_valid_q;

	logic [1:0]         kind_q;
	logic [AW-1:0]      ia_q;
	logic [AW-1:0]      ib_q;
	logic signed [31:0] in_pos_q [3];
	logic signed [31:0] in_vel_q [3];
	logic [30:0]        in_rad_q;
	logic [30:0]        in_mass_q;

	logic [AW-1:0] idx_map [64];

	rec_t          mem [SPHERE_COUNT];
	rec_t          rd_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	rec_t          wr_data;
	rec_t          rec_upd;

	rec_t               rec_a_q;
	rec_t               rec_b_q;
	logic signed [32:0] d_q  [3];
	logic signed [32:0] vd_q [3];
	logic [31:0]        rs_q;
	logic [65:0]        d2_q;
	logic [63:0]        rs2_q;
	logic [31:0]        dist_q;
	logic signed [17:0] n_q [3];
	logic signed [51:0] rv_q;
	logic [36:0]        k_q;
	logic [24:0]        w_q  [2];
	logic [36:0]        kx_q [2];
	logic [30:0]        half_q;

	logic signed [37:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [71:0] prod_q;

	logic [5:0] out_idx_q;
	rec_t       out_rec_q;
	logic       out_contact_q;
	logic       out_last_q;

	logic [1:0]         ax;
	logic               side_b;
	logic signed [32:0] dabs;
	logic [51:0]        neg_rv;
	logic [31:0]        msum;
	logic               contact_now;
	logic               out_free;
	logic signed [55:0] frac_prod;
	logic [31:0]        half_diff;
	logic [16:0]        quot_n;

	div_req_t          dv_req;
	logic              dv_done;
	logic [QUOT_W-1:0] dv_quot;
	sqrt_req_t         sq_req;
	logic              sq_done;
	logic [31:0]       sq_root;

	for (genvar g = 0; g < 64; g++) begin : g_idx
		assign idx_map[g] = AW'(g % SPHERE_COUNT);
	end

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {15'd0, restitution_q} : 32'd0;

	assign req_stall   = (state_q != S_IDLE);
	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign side_b      = (cnt_q >= 3'd3);
	assign ax          = side_b ? 2'(cnt_q - 3'd3) : cnt_q[1:0];
	assign dabs        = d_q[ax][32] ? -d_q[ax] : d_q[ax];
	assign neg_rv      = 52'(-rv_q);
	assign msum        = {1'b0, rec_a_q.mass} + {1'b0, rec_b_q.mass};
	assign contact_now = (d2_q != '0) && (d2_q < {2'b00, rs2_q});
	assign frac_prod   = trunc_frac(prod_q);
	assign half_diff   = rs_q - dist_q;
	assign quot_n      = dv_quot[16:0];

	always_comb begin
		rec_upd = rd_q;
		for (int i = 0; i < 3; i++) begin
			case (kind_q)
				KIND_LOAD: begin
					rec_upd.pos[i] = in_pos_q[i];
					rec_upd.vel[i] = in_vel_q[i];
				end
				KIND_ACCEL: begin
					rec_upd.vel[i] = sat32(40'($signed(rd_q.vel[i])) + 40'(in_vel_q[i]));
				end
				KIND_ADVANCE: begin
					rec_upd.pos[i] = sat32(40'($signed(rd_q.pos[i]))
						+ 40'($signed(rd_q.vel[i])));
				end
				default: begin
					rec_upd.pos[i] = rd_q.pos[i];
				end
			endcase
		end
		if (kind_q == KIND_LOAD) begin
			rec_upd.radius = in_rad_q;
			rec_upd.mass   = (in_mass_q == '0) ? 31'd1 : in_mass_q;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				if (cnt_q == 3'd3) begin
					mul_a = 38'({1'b0, rs_q});
					mul_b = 34'({1'b0, rs_q});
				end else begin
					mul_a = 38'(d_q[ax]);
					mul_b = 34'(d_q[ax]);
				end
			end
			S_RV: begin
				mul_a = 38'(n_q[ax]);
				mul_b = 34'(vd_q[ax]);
			end
			S_K: begin
				mul_a = 38'({1'b0, neg_rv[51:FRAC_BITS]});
				mul_b = 34'({1'b0, 18'(18'd65536 + {1'b0, restitution_q})});
			end
			S_KW: begin
				mul_a = 38'({1'b0, k_q});
				mul_b = 34'({1'b0, w_q[cnt_q[0]]});
			end
			S_DV: begin
				mul_a = 38'({1'b0, kx_q[side_b]});
				mul_b = 34'(n_q[ax]);
			end
			S_PS: begin
				mul_a = 38'({1'b0, half_q});
				mul_b = 34'(n_q[ax]);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sphere record memory
	assign rd_addr = (state_q == S_IDLE) ? idx_map[index_a] : ib_q;
	assign mem_we  = (state_q == S_WRA) || (state_q == S_WRB);
	assign wr_addr = (state_q == S_WRA) ? ia_q : ib_q;
	assign wr_data = (state_q == S_WRA) ? rec_a_q : rec_b_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		dv_req.start = (state_q == S_NDIV) || (state_q == S_WDIV);
		if (state_q == S_NDIV || state_q == S_NDW) begin
			dv_req.count = NORM_DIV_STEPS;
			dv_req.num   = dabs[31:0];
			dv_req.den   = dist_q;
		end else begin
			dv_req.count = WEIGHT_DIV_STEPS;
			dv_req.num   = cnt_q[0] ? {1'b0, rec_a_q.mass} : {1'b0, rec_b_q.mass};
			dv_req.den   = msum;
		end
		sq_req.start = (state_q == S_CHK) && contact_now;
		sq_req.x     = d2_q[63:0];
	end

	scie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dv_req),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	scie_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			restitution_q <= RESTITUTION_RESET;
			contact_q     <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == 1'b0) begin
				restitution_q <= pwdata[16:0];
			end
			if ((state_q == S_EMA || state_q == S_EMB) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q   <= S_RDA;
						contact_q <= 1'b0;
						cnt_q     <= '0;
					end
				end
				S_RDA:  state_q <= (kind_q == KIND_COLLIDE) ? S_RDB : S_WRA;
				S_RDB:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_SQ;
				S_SQ:   state_q <= S_SQA;
				S_SQA: begin
					if (cnt_q == 3'd3) begin
						cnt_q   <= '0;
						state_q <= S_CHK;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_SQ;
					end
				end
				S_CHK: begin
					if (contact_now) begin
						contact_q <= 1'b1;
						state_q   <= S_SQRT;
					end else begin
						state_q <= S_EMA;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_NDIV;
					end
				end
				S_NDIV: state_q <= S_NDW;
				S_NDW: begin
					if (dv_done) begin
						if (cnt_q == 3'd2) begin
							cnt_q   <= '0;
							state_q <= S_RV;
						end else begin
							cnt_q   <= cnt_q + 3'd1;
							state_q <= S_NDIV;
						end
					end
				end
				S_RV:  state_q <= S_RVA;
				S_RVA: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= '0;
						state_q <= S_IMP;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_RV;
					end
				end
				S_IMP:  state_q <= rv_q[51] ? S_K : S_HALF;
				S_K:    state_q <= S_KA;
				S_KA:   state_q <= S_WDIV;
				S_WDIV: state_q <= S_WDW;
				S_WDW: begin
					if (dv_done) begin
						if (cnt_q == 3'd1) begin
							cnt_q   <= '0;
							state_q <= S_KW;
						end else begin
							cnt_q   <= cnt_q + 3'd1;
							state_q <= S_WDIV;
						end
					end
				end
				S_KW:  state_q <= S_KWA;
				S_KWA: begin
					if (cnt_q == 3'd1) begin
						cnt_q   <= '0;
						state_q <= S_DV;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_KW;
					end
				end
				S_DV:  state_q <= S_DVA;
				S_DVA: begin
					if (cnt_q == 3'd5) begin
						cnt_q   <= '0;
						state_q <= S_HALF;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_DV;
					end
				end
				S_HALF: state_q <= S_PS;
				S_PS:   state_q <= S_PSA;
				S_PSA: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= '0;
						state_q <= S_WRA;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_PS;
					end
				end
				S_WRA: state_q <= (kind_q == KIND_COLLIDE) ? S_WRB : S_EMA;
				S_WRB: state_q <= S_EMA;
				S_EMA: begin
					if (out_free) begin
						state_q <= (kind_q == KIND_COLLIDE) ? S_EMB : S_IDLE;
					end
				end
				S_EMB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					kind_q      <= kind;
					ia_q        <= idx_map[index_a];
					ib_q        <= idx_map[index_b];
					in_pos_q[0] <= pos_x;
					in_pos_q[1] <= pos_y;
					in_pos_q[2] <= pos_z;
					in_vel_q[0] <= vel_x;
					in_vel_q[1] <= vel_y;
					in_vel_q[2] <= vel_z;
					in_rad_q    <= radius;
					in_mass_q   <= mass;
				end
			end
			S_RDA: rec_a_q <= rec_upd;
			S_RDB: rec_b_q <= rd_q;
			S_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i]  <= 33'($signed(rec_b_q.pos[i])) - 33'($signed(rec_a_q.pos[i]));
					vd_q[i] <= 33'($signed(rec_b_q.vel[i])) - 33'($signed(rec_a_q.vel[i]));
				end
				rs_q <= {1'b0, rec_a_q.radius} + {1'b0, rec_b_q.radius};
				d2_q <= '0;
				rv_q <= '0;
			end
			S_SQA: begin
				if (cnt_q == 3'd3) begin
					rs2_q <= prod_q[63:0];
				end else begin
					d2_q <= d2_q + prod_q[65:0];
				end
			end
			S_SQRT: begin
				if (sq_done) begin
					dist_q <= sq_root;
				end
			end
			S_NDW: begin
				if (dv_done) begin
					n_q[ax] <= d_q[ax][32] ? -$signed({1'b0, quot_n}) : $signed({1'b0, quot_n});
				end
			end
			S_RVA: rv_q <= rv_q + prod_q[51:0];
			S_KA:  k_q  <= prod_q[52:16];
			S_WDW: begin
				if (dv_done) begin
					w_q[cnt_q[0]] <= dv_quot;
				end
			end
			S_KWA: kx_q[cnt_q[0]] <= prod_q[60:24];
			S_DVA: begin
				if (side_b) begin
					rec_b_q.vel[ax] <= sat32(40'($signed(rec_b_q.vel[ax])) + 40'(frac_prod));
				end else begin
					rec_a_q.vel[ax] <= sat32(40'($signed(rec_a_q.vel[ax])) - 40'(frac_prod));
				end
			end
			S_HALF: half_q <= half_diff[31:1];
			S_PSA: begin
				rec_a_q.pos[ax] <= sat32(40'($signed(rec_a_q.pos[ax])) - 40'(frac_prod));
				rec_b_q.pos[ax] <= sat32(40'($signed(rec_b_q.pos[ax])) + 40'(frac_prod));
			end
			S_EMA: begin
				if (out_free) begin
					out_idx_q     <= 6'(ia_q);
					out_rec_q     <= rec_a_q;
					out_contact_q <= contact_q;
					out_last_q    <= (kind_q != KIND_COLLIDE);
				end
			end
			S_EMB: begin
				if (out_free) begin
					out_idx_q     <= 6'(ib_q);
					out_rec_q     <= rec_b_q;
					out_contact_q <= contact_q;
					out_last_q    <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign sphere_index = out_idx_q;
	assign new_pos_x    = out_rec_q.pos[0];
	assign new_pos_y    = out_rec_q.pos[1];
	assign new_pos_z    = out_rec_q.pos[2];
	assign new_vel_x    = out_rec_q.vel[0];
	assign new_vel_y    = out_rec_q.vel[1];
	assign new_vel_z    = out_rec_q.vel[2];
	assign contact      = out_contact_q;
	assign last         = out_last_q;

	`SCIE_ASSERT(a_contact_collide, (state_q == S_EMA && contact_q) |-> (kind_q == KIND_COLLIDE), "contact flagged on a non-collide transaction")
	`SCIE_ASSERT(a_sqrt_done_state, sq_done |-> (state_q == S_SQRT), "square root finished outside its wait state")
	`SCIE_ASSERT(a_div_done_state, dv_done |-> (state_q == S_NDW || state_q == S_WDW), "divider finished outside its wait states")
	`SCIE_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!rsp_valid && !req_stall), "outputs active during reset")

endmodule

FILE: sim/testbench.sv
// Self-checking bench for sphere_collision_impulse_engine_unit: drives load, accelerate,
// advance and collide transactions, predicts every updated sphere record and compares.
// Depends on scie_pkg and the engine RTL.
module testbench;
	import scie_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  ia;
		logic [5:0]  ib;
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic [30:0] rad;
		logic [30:0] mas;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  idx;
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic        hit;
		logic        fin;
	} record_t;

	logic clk = 0, arst_n = 1;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
	logic [1:0] kind = 0;
	logic [5:0] index_a = 0, index_b = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
	logic [30:0] radius = 0, mass = 0;
	logic [5:0] sphere_index;
	logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
	logic contact, last;

	sphere_collision_impulse_engine_unit dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	cmd_t pending_cmds[$];
	record_t expected_records[$];
	logic signed [31:0] pos_tab[64][3], vel_tab[64][3];
	logic [31:0] rad_tab[64], mass_tab[64];
	bit loaded[64];
	logic [16:0] rest_coef = RESTITUTION_RESET;
	int errors = 0, records_seen = 0, contacts_seen = 0, idle_cycles = 0;
	int send_gap = 0, recv_gap = 0, hold_cycles = 0, items_sent = 0;
	bit sender_paused = 0;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit resolve_contact(int a, int b);
		longint d[3], n[3], rv, da, db, s;
		longint unsigned rs, d2, mg, sq, cdist, av, k, ma, mb, ms, wa, wb, ka, kb, half;
		rv = 0;
		d2 = 0;
		rs = 64'(rad_tab[a]) + 64'(rad_tab[b]);
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(pos_tab[b][i]) - longint'(pos_tab[a][i]);
			mg = d[i] < 0 ? -d[i] : d[i];
			if (mg >= rs) return 0;
			sq = mg * mg;
			d2 = (d2 > 64'hffffffffffffffff - sq) ? 64'hffffffffffffffff : d2 + sq;
		end
		if (d2 == 0 || d2 >= rs * rs) return 0;
		cdist = root64(d2);
		for (int i = 0; i < 3; i++) begin
			n[i] = (d[i] * 65536) / longint'(cdist);
			rv += n[i] * (longint'(vel_tab[b][i]) - longint'(vel_tab[a][i]));
		end
		if (rv < 0) begin
			av = (-rv) / 65536;
			k = (av * (65536 + 64'(rest_coef))) >> 16;
			ma = mass_tab[a];
			mb = mass_tab[b];
			ms = ma + mb;
			wa = (mb << 24) / ms;
			wb = (ma << 24) / ms;
			ka = (k * wa) >> 24;
			kb = (k * wb) >> 24;
			for (int i = 0; i < 3; i++) begin
				da = (longint'(ka) * n[i]) / 65536;
				db = (longint'(kb) * n[i]) / 65536;
				vel_tab[a][i] = clamp32(longint'(vel_tab[a][i]) - da);
				vel_tab[b][i] = clamp32(longint'(vel_tab[b][i]) + db);
			end
		end
		half = (rs - cdist) >> 1;
		for (int i = 0; i < 3; i++) begin
			s = (longint'(half) * n[i]) / 65536;
			pos_tab[a][i] = clamp32(longint'(pos_tab[a][i]) - s);
			pos_tab[b][i] = clamp32(longint'(pos_tab[b][i]) + s);
		end
		return 1;
	endfunction

	function automatic record_t sphere_record(int i, bit hit, bit fin);
		return '{6'(i), pos_tab[i][0], pos_tab[i][1], pos_tab[i][2],
			vel_tab[i][0], vel_tab[i][1], vel_tab[i][2], hit, fin};
	endfunction

	function automatic void predict_records(cmd_t c);
		int a, b;
		bit hit;
		a = c.ia;
		b = c.ib;
		case (c.kind)
			KIND_LOAD: begin
				pos_tab[a] = '{c.px, c.py, c.pz};
				vel_tab[a] = '{c.vx, c.vy, c.vz};
				rad_tab[a] = c.rad;
				mass_tab[a] = c.mas == 0 ? 1 : c.mas;
			end
			KIND_ACCEL: begin
				vel_tab[a][0] = clamp32(longint'(vel_tab[a][0]) + c.vx);
				vel_tab[a][1] = clamp32(longint'(vel_tab[a][1]) + c.vy);
				vel_tab[a][2] = clamp32(longint'(vel_tab[a][2]) + c.vz);
			end
			KIND_ADVANCE: begin
				for (int i = 0; i < 3; i++)
					pos_tab[a][i] = clamp32(longint'(pos_tab[a][i]) + vel_tab[a][i]);
			end
			default: begin
				hit = resolve_contact(a, b);
				expected_records.push_back(sphere_record(a, hit, 0));
				expected_records.push_back(sphere_record(b, hit, 1));
				return;
			end
		endcase
		expected_records.push_back(sphere_record(a, 0, 1));
	endfunction

	function automatic logic signed [31:0] rand_word(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'sh7fffffff - $urandom_range(0, 3);
			2: return 32'sh80000000 + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 32'h000c0000)) - 32'sh00060000;
		endcase
	endfunction

	function automatic int pick_loaded();
		int i;
		do i = $urandom_range(0, 63); while (!loaded[i]);
		return i;
	endfunction

	function automatic cmd_t make_load(int i, logic signed [31:0] c, int wide);
		cmd_t t;
		t.kind = KIND_LOAD;
		t.ia = i;
		t.ib = $urandom;
		t.px = c + rand_word(3);
		t.py = c / 2 + rand_word(3);
		t.pz = rand_word(3);
		t.vx = wide ? rand_word($urandom_range(0, 3)) : rand_word(3);
		t.vy = wide ? rand_word($urandom_range(0, 3)) : rand_word(3);
		t.vz = rand_word(3);
		t.rad = wide ? $urandom : $urandom_range(0, 31'h00080000);
		t.mas = $urandom_range(0, 9) == 0 ? 0 : (wide ? $urandom : $urandom_range(1, 31'h00100000));
		loaded[i] = 1;
		return t;
	endfunction

	function automatic cmd_t make_cmd(int k, int a, int b);
		cmd_t t;
		t = '0;
		t.kind = k;
		t.ia = a;
		t.ib = b;
		t.vx = rand_word($urandom_range(0, 3));
		t.vy = rand_word($urandom_range(0, 3));
		t.vz = rand_word(3);
		t.px = $urandom;
		t.py = $urandom;
		t.pz = $urandom;
		t.rad = $urandom;
		t.mas = $urandom;
		return t;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_records(pending_cmds.pop_front());
				items_sent++;
			end
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 0;
			end else if (pending_cmds.size() > 0 && !sender_paused &&
					(!req_valid || !req_stall || pending_cmds.size() > 0)) begin
				if (!req_valid || !req_stall) begin
					if (!req_valid || !req_stall) begin
						if (req_valid && !req_stall && $urandom_range(0, 5) == 0) begin
							send_gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
								: $urandom_range(1, 3);
							req_valid <= 0;
						end else if (pending_cmds.size() > 0) begin
							req_valid <= 1;
							{kind, index_a, index_b, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
								radius, mass} <= pending_cmds[0];
						end else begin
							req_valid <= 0;
						end
					end
				end
			end else if (!req_valid || !req_stall) begin
				req_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		record_t exp_r, got;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				got = '{sphere_index, new_pos_x, new_pos_y, new_pos_z,
					new_vel_x, new_vel_y, new_vel_z, contact, last};
				records_seen++;
				if (expected_records.size() == 0) begin
					errors++;
					$display("%0t unexpected record %h", $time, got);
				end else begin
					exp_r = expected_records.pop_front();
					if (got.hit) contacts_seen++;
					if (got !== exp_r) begin
						errors++;
						$display("%0t mismatch expected %h actual %h", $time, exp_r, got);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_stall <= 1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_stall <= 1;
			end else if ($urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 50) : $urandom_range(0, 2);
				rsp_stall <= 1;
			end else begin
				rsp_stall <= 0;
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 20000) begin
				$display("sphere_collision_impulse_engine_unit test failed");
				$finish;
			end
		end
	end

	task automatic write_restitution(logic [16:0] v);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= 0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		rest_coef = v;
	endtask

	task automatic drain();
		wait (pending_cmds.size() == 0 && !req_valid);
		wait (expected_records.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int a, b, r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				pending_cmds.push_back(make_load($urandom_range(0, 63),
					rand_word(3) * 8, $urandom_range(0, 4) == 0));
			end else if (r < 22) begin
				pending_cmds.push_back(make_cmd(KIND_ACCEL, pick_loaded(), $urandom));
			end else if (r < 32) begin
				pending_cmds.push_back(make_cmd(KIND_ADVANCE, pick_loaded(), $urandom));
			end else begin
				a = pick_loaded();
				b = $urandom_range(0, 15) == 0 ? a : pick_loaded();
				if ($urandom_range(0, 1)) begin
					pending_cmds.push_back(make_load(b, pos_tab[a][0], 0));
					pending_cmds[$].px = pending_cmds[$].px;
				end
				pending_cmds.push_back(make_cmd(KIND_COLLIDE, a, b));
			end
		end
	endtask

	initial begin
		cmd_t t;
		arst_n <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		t = make_load(0, 0, 0);
		t.px = 0; t.py = 0; t.pz = 0; t.vx = 32'sh00010000; t.vy = 0; t.vz = 0;
		t.rad = 31'h00010000; t.mas = 0;
		pending_cmds.push_back(t);
		t = make_load(1, 0, 0);
		t.px = 32'sh00018000; t.py = 0; t.pz = 0; t.vx = -32'sh00010000; t.vy = 0; t.vz = 0;
		t.rad = 31'h00010000; t.mas = 31'h7fffffff;
		pending_cmds.push_back(t);
		pending_cmds.push_back(make_cmd(KIND_COLLIDE, 0, 1));
		pending_cmds.push_back(make_cmd(KIND_COLLIDE, 1, 1));
		t = make_load(63, 0, 0);
		t.px = 32'sh7fffffff; t.py = 32'sh80000000; t.pz = 0; t.vx = 32'sh7fffffff;
		t.vy = 32'sh80000000; t.vz = -1; t.rad = 31'h7fffffff; t.mas = 31'h7fffffff;
		pending_cmds.push_back(t);
		t = make_cmd(KIND_ACCEL, 63, 0);
		t.vx = 32'sh7fffffff; t.vy = 32'sh80000000; t.vz = 32'sh80000000;
		pending_cmds.push_back(t);
		pending_cmds.push_back(make_cmd(KIND_ADVANCE, 63, 0));
		pending_cmds.push_back(make_cmd(KIND_COLLIDE, 0, 63));
		pending_cmds.push_back(make_load(2, 32'sh01000000, 0));
		pending_cmds.push_back(make_cmd(KIND_COLLIDE, 2, 0));
		pending_cmds.push_back(make_cmd(KIND_ADVANCE, 0, 63));
		drain();
		write_restitution(17'd0);
		random_phase(120);
		wait (pending_cmds.size() < 60);
		hold_cycles = 1500;
		drain();
		write_restitution(17'd65536);
		random_phase(270);
		wait (pending_cmds.size() < 100);
		sender_paused = 1;
		wait (expected_records.size() == 0);
		sender_paused = 0;
		drain();
		write_restitution(17'h1ffff);
		random_phase(230);
		drain();
		write_restitution(RESTITUTION_RESET);
		random_phase(230);
		drain();
		$display("ran %0d transactions, checked %0d records, %0d with contact",
			items_sent, records_seen, contacts_seen);
		$display("restitution swept 0, 1.0, 17-bit max and reset; long output hold covered");
		if (errors == 0 && expected_records.size() == 0) begin
			$display("sphere_collision_impulse_engine_unit test passed");
		end else begin
			$display("sphere_collision_impulse_engine_unit test failed");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/scie_pkg.sv
design/scie_div.sv
design/scie_sqrt.sv
design/sphere_collision_impulse_engine_unit.sv
sim/testbench.sv
